// ----- hw/rtl/ins_pkg.sv -----
package ins_pkg;

  // Width of one element of the set.
  localparam int VALUE_W = 64;

  typedef logic signed [VALUE_W-1:0] value_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic   valid;
    logic   lt;
    value_t value;
  } ins_link_t;

  // Commands that every cell of the chain sees in the same cycle.
  typedef struct packed {
    logic insert;
    logic shift;
  } ins_ctrl_t;

  // Stands to the left of the first cell: always occupied, never larger.
  localparam ins_link_t HEAD_LINK = '{valid: 1'b1, lt: 1'b0, value: '0};

  // Stands to the right of the last cell: always empty.
  localparam ins_link_t TAIL_LINK = '{valid: 1'b0, lt: 1'b0, value: '0};

endpackage

// ----- hw/rtl/insertion_sorter.sv -----
// Stable ascending sorter for sets of up to MAX_ELEMS signed 64-bit elements.
// Elements are taken one item per cycle while a set is being collected; each
// lands in its sorted place in the cell chain in the cycle it is accepted,
// equal elements keeping their arrival order. The item flagged last starts
// the drain: from the next cycle the sorted set leaves one result per cycle
// while out_stall is low, smallest first, as the chain shifts one place toward
// its head, and in_stall stays high until the final result has been taken.
// Elements that arrive at a full chain are dropped, including a last one, and
// every result of that set carries out_overflow.
module insertion_sorter
  import ins_pkg::*;
#(
  parameter int MAX_ELEMS = 32
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  value_t in_value,
  input  logic   in_last,
  output logic   out_valid,
  input  logic   out_stall,
  output value_t out_value_res,
  output logic   out_last_res,
  output logic   out_overflow
);

  ins_link_t cell_link [MAX_ELEMS];
  ins_ctrl_t ctrl;
  logic      in_acc;
  logic      full;
  logic      out_done;
  logic      drain_r;
  logic      drain_nxt;
  logic      dropped_r;
  logic      dropped_nxt;

  // Chain of cells, head at index zero.
  for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
    ins_link_t left_link;
    ins_link_t right_link;
    if (i == 0) begin : g_head
      assign left_link = HEAD_LINK;
    end else begin : g_mid_l
      assign left_link = cell_link[i-1];
    end
    if (i == MAX_ELEMS - 1) begin : g_tail
      assign right_link = TAIL_LINK;
    end else begin : g_mid_r
      assign right_link = cell_link[i+1];
    end
    ins_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .new_value (in_value),
      .left      (left_link),
      .right     (right_link),
      .link      (cell_link[i])
    );
  end

  // Handshakes and chain commands.
  assign full        = cell_link[MAX_ELEMS-1].valid;
  assign in_stall    = drain_r;
  assign in_acc      = in_valid && !drain_r;
  assign out_valid   = drain_r && cell_link[0].valid;
  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_valid && !out_stall;
  assign out_done    = ctrl.shift && out_last_res;

  // Results come straight from the head cell.
  assign out_value_res = cell_link[0].value;
  assign out_last_res  = !cell_link[1].valid;
  assign out_overflow  = dropped_r;

  // Collect / drain mode and the overflow flag of the current set.
  always_comb begin
    drain_nxt   = drain_r;
    dropped_nxt = dropped_r;
    if (in_acc && in_last) begin
      drain_nxt = 1'b1;
    end else if (out_done) begin
      drain_nxt = 1'b0;
    end
    if (out_done) begin
      dropped_nxt = 1'b0;
    end else if (in_acc && full) begin
      dropped_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r   <= 1'b0;
      dropped_r <= 1'b0;
    end else begin
      drain_r   <= drain_nxt;
      dropped_r <= dropped_nxt;
    end
  end

endmodule

// ----- hw/rtl/ins_cell.sv -----
module ins_cell
  import ins_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ins_ctrl_t ctrl,
  input  value_t    new_value,
  input  ins_link_t left,
  input  ins_link_t right,
  output ins_link_t link
);

  logic   valid_r;
  logic   valid_nxt;
  value_t value_r;
  value_t value_nxt;
  logic   lt;

  // The new element goes before this one only when strictly less.
  assign lt = valid_r && ($signed(new_value) < $signed(value_r));

  // Drain moves everything one place toward the head. Insert lets the cells
  // holding larger elements take their left neighbor's element, and the first
  // such cell (or the first empty one) take the new element.
  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    priority if (ctrl.shift) begin
      valid_nxt = right.valid;
      value_nxt = right.value;
    end else if (ctrl.insert && (lt || (!valid_r && left.valid))) begin
      valid_nxt = 1'b1;
      value_nxt = left.lt ? left.value : new_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign link = '{valid: valid_r, lt: lt, value: value_r};

endmodule

// ----- hw/rtl/ins_checker.sv -----
module ins_checker
  import ins_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_stall,
  input logic   in_last,
  input logic   out_valid,
  input logic   out_stall,
  input value_t out_value_res,
  input logic   out_last_res,
  input logic   out_overflow
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_res)
      && $stable(out_last_res) && $stable(out_overflow))
    else $error("stalled result changed");

  // The item that closes a set starts the results in the next cycle.
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> out_valid)
    else $error("no result after the last item");

  // No item is taken while results are pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("item accepted during drain");

  // The final result ends the set.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_res |=> !out_valid)
    else $error("result after the final one");

  // Within a set, results follow without gaps and never decrease.
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_res |=> out_valid
      && ($signed(out_value_res) >= $signed($past(out_value_res))))
    else $error("results out of order");

endmodule

bind insertion_sorter ins_checker u_ins_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_last       (in_last),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_value_res (out_value_res),
  .out_last_res  (out_last_res),
  .out_overflow  (out_overflow)
);
